// ===== design/cmp_pkg.sv =====
// Shared widths, limits and the stored component record for the mass properties core.
package cmp_pkg;

    localparam int MAX_COMPONENTS = 64;
    localparam int IDX_W          = $clog2(MAX_COMPONENTS);
    localparam int CNT_W          = $clog2(MAX_COMPONENTS + 1);

    localparam int MASS_W    = 32;
    localparam int POS_W     = 24;
    localparam int INER_W    = 32;
    localparam int LIMIT_W   = 31;
    localparam int MSUM_W    = 40;
    localparam int MOM_W     = 64;
    localparam int TOT_W     = 63;
    localparam int IN_DATA_W = 200;
    localparam int OUT_DATA_W = 304;

    localparam logic [LIMIT_W-1:0] MASS_LIMIT_RESET = 31'd1024000000;
    localparam logic [MSUM_W-1:0]  MASS_SUM_MAX     = {MSUM_W{1'b1}};
    localparam logic [TOT_W-1:0]   INERTIA_MAX      = {TOT_W{1'b1}};

    typedef struct packed {
        logic [MASS_W-1:0]        mass;
        logic signed [POS_W-1:0]  px;
        logic signed [POS_W-1:0]  py;
        logic signed [POS_W-1:0]  pz;
        logic [INER_W-1:0]        ix;
        logic [INER_W-1:0]        iy;
        logic [INER_W-1:0]        iz;
    } comp_entry_t;

endpackage

// ===== design/composite_mass_properties_core.sv =====
// Top level: composite mass, centre of mass and parallel-axis inertia of a component set.
//
// Components arrive on the s_ channel, one transaction per component; s_tlast marks the
// last of a set. While a set loads, one component is taken per cycle: it is checked,
// written into the component memory and its mass and moment folded into running sums
// through a two-stage multiply/accumulate pipe.
// After the last component the input stalls: the pipe drains, three radix-2 dividers that
// share one step counter find the three centre coordinates (one quotient bit per cycle),
// then the component memory is swept once, one entry per cycle, through a seven-stage
// parallel-axis pipe. A rejected set skips the compute and answers after the drain.
// The single result per set sits in an output register on the m_ channel; if the
// receiver stalls, the block holds the result, and the next set may load but waits in
// its final state until the register is free.
// mass_limit is written through cfg_valid/cfg_data, always ready; the user must write it
// only while the block is idle, which the block itself does not enforce.
// Reset clears the sums, count, reject flag and mass_limit (to its default); the memory
// is not cleared, as only entries written in the current set are read.
module composite_mass_properties_core
    import cmp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [LIMIT_W-1:0]     cfg_data,    // mass_limit
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // mass, pos_x, pos_y, pos_z, own_inertia_x, own_inertia_y, own_inertia_z
    input  logic [IN_DATA_W-1:0]   s_tdata,
    input  logic                   s_tuser,     // has_id
    input  logic                   s_tlast,     // last_component
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // total_mass, center_x, center_y, center_z, total_inertia_x/y/z, zero pad
    output logic [OUT_DATA_W-1:0]  m_tdata,
    output logic                   m_tuser      // valid_res
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DRAIN = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_CEN   = 3'd3;
    localparam logic [2:0] ST_PASS  = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                reject_reg;
    logic                bad_reg;

    comp_entry_t         mem [MAX_COMPONENTS];
    comp_entry_t         mem_q;

    // input decode
    logic signed [MASS_W-1:0] in_mass;
    logic signed [POS_W-1:0]  in_px, in_py, in_pz;
    logic signed [INER_W-1:0] in_ix, in_iy, in_iz;
    logic                     in_fire, in_ok;
    comp_entry_t              in_entry;

    assign in_mass = s_tdata[31:0];
    assign in_px   = s_tdata[55:32];
    assign in_py   = s_tdata[79:56];
    assign in_pz   = s_tdata[103:80];
    assign in_ix   = s_tdata[135:104];
    assign in_iy   = s_tdata[167:136];
    assign in_iz   = s_tdata[199:168];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;

    always_comb
    begin
        in_ok = !reject_reg && s_tuser && !in_mass[31] && (in_mass != '0)
             && (in_mass[30:0] <= limit_reg)
             && !in_ix[31] && !in_iy[31] && !in_iz[31]
             && (count_reg < CNT_W'(MAX_COMPONENTS));
        in_entry.mass = in_mass;
        in_entry.px   = in_px;
        in_entry.py   = in_py;
        in_entry.pz   = in_pz;
        in_entry.ix   = in_ix;
        in_entry.iy   = in_iy;
        in_entry.iz   = in_iz;
    end

    // accumulate pipe: A holds the accepted component, B the moments
    logic                      a_valid_reg, b_valid_reg;
    logic signed [MASS_W-1:0]  a_mass_reg;
    logic signed [POS_W-1:0]   a_px_reg, a_py_reg, a_pz_reg;
    logic signed [55:0]        b_mx_reg, b_my_reg, b_mz_reg;
    logic [MSUM_W-1:0]         msum_reg;
    logic signed [MOM_W-1:0]   mom_x_reg, mom_y_reg, mom_z_reg;
    logic [MSUM_W:0]           msum_wide;

    assign msum_wide = {1'b0, msum_reg} + (MSUM_W+1)'(a_mass_reg[30:0]);

    function automatic logic signed [MOM_W-1:0] sat_add_mom(
        input logic signed [MOM_W-1:0] s,
        input logic signed [55:0]      p
    );
        logic signed [MOM_W:0] w;
        w = (MOM_W+1)'(s) + (MOM_W+1)'(p);
        if (w[MOM_W] != w[MOM_W-1])
            sat_add_mom = w[MOM_W] ? {1'b1, {(MOM_W-1){1'b0}}} : {1'b0, {(MOM_W-1){1'b1}}};
        else
            sat_add_mom = w[MOM_W-1:0];
    endfunction

    // divider: three axes share the step counter
    logic [MOM_W-1:0]   dvd_x_reg, dvd_y_reg, dvd_z_reg;
    logic [MSUM_W-1:0]  rem_x_reg, rem_y_reg, rem_z_reg;
    logic               neg_x_reg, neg_y_reg, neg_z_reg;
    logic [5:0]         step_reg;

    function automatic logic [MOM_W-1:0] mag64(input logic signed [MOM_W-1:0] v);
        mag64 = v[MOM_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [MSUM_W+MOM_W-1:0] div_step(
        input logic [MSUM_W-1:0] rem,
        input logic [MOM_W-1:0]  dvd,
        input logic [MSUM_W-1:0] d
    );
        logic [MSUM_W:0]   trial;
        logic [MSUM_W-1:0] r;
        logic              q;
        trial = {rem, dvd[MOM_W-1]};
        q     = (trial >= {1'b0, d});
        r     = q ? MSUM_W'(trial - {1'b0, d}) : trial[MSUM_W-1:0];
        div_step = {r, dvd[MOM_W-2:0], q};
    endfunction

    function automatic logic signed [POS_W-1:0] clamp_c(
        input logic [MOM_W-1:0] q,
        input logic             neg
    );
        if (neg)
            clamp_c = (q > MOM_W'(64'd8388608)) ? 24'sh800000 : (~q[23:0] + 1'b1);
        else
            clamp_c = (q > MOM_W'(64'd8388607)) ? 24'sh7FFFFF : q[23:0];
    endfunction

    logic signed [POS_W-1:0] cx_reg, cy_reg, cz_reg;

    // parallel-axis pipe
    logic [CNT_W-1:0]   k_reg;
    logic               issue;
    logic               rv_reg, sv_reg, tv_reg, uv_reg, vv_reg, wv_reg;
    logic [MASS_W-1:0]  s_mass_reg, t_mass_reg;
    logic [INER_W-1:0]  s_ix_reg, s_iy_reg, s_iz_reg, t_ix_reg, t_iy_reg, t_iz_reg;
    logic [INER_W-1:0]  u_ix_reg, u_iy_reg, u_iz_reg, v_ix_reg, v_iy_reg, v_iz_reg;
    logic [49:0]        sqx_reg, sqy_reg, sqz_reg;
    logic [49:0]        bx_reg, by_reg, bz_reg;
    logic [49:0]        hix_reg, hiy_reg, hiz_reg;
    logic [63:0]        lox_reg, loy_reg, loz_reg;
    logic [47:0]        termx_reg, termy_reg, termz_reg;
    logic [48:0]        incx_reg, incy_reg, incz_reg;
    logic [TOT_W-1:0]   accx_reg, accy_reg, accz_reg;
    logic               pass_done;

    assign issue = (state_reg == ST_PASS) && (k_reg < count_reg);
    assign pass_done = (state_reg == ST_PASS) && (k_reg == count_reg)
                    && !rv_reg && !sv_reg && !tv_reg && !uv_reg && !vv_reg && !wv_reg;

    function automatic logic [49:0] sq_dist(
        input logic signed [POS_W-1:0] p,
        input logic signed [POS_W-1:0] c
    );
        logic signed [POS_W:0] d;
        logic [POS_W:0]        a;
        d = (POS_W+1)'(p) - (POS_W+1)'(c);
        a = d[POS_W] ? (~d + 1'b1) : d;
        sq_dist = 50'(a) * 50'(a);
    endfunction

    function automatic logic [47:0] shr34(input logic [49:0] hi, input logic [63:0] lo);
        logic [81:0] w;
        w = {hi, 32'd0} + 82'(lo);
        shr34 = w[81:34];
    endfunction

    function automatic logic [TOT_W-1:0] sat_acc(
        input logic [TOT_W-1:0] s,
        input logic [48:0]      p
    );
        logic [TOT_W:0] w;
        w = {1'b0, s} + (TOT_W+1)'(p);
        sat_acc = (w >= {1'b0, INERTIA_MAX}) ? INERTIA_MAX : w[TOT_W-1:0];
    endfunction

    // output register
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_user_reg;
    logic                  out_load;
    logic                  res_ok;

    assign out_load = (state_reg == ST_FIN) && (!out_valid_reg || m_tready);
    assign res_ok   = !bad_reg && (accx_reg != '0) && (accy_reg != '0) && (accz_reg != '0);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_fire && s_tlast) state_next = ST_DRAIN;
            ST_DRAIN:
                if (!a_valid_reg && !b_valid_reg)
                    state_next = (reject_reg || msum_reg == '0) ? ST_FIN : ST_DIV;
            ST_DIV:   if (step_reg == '0) state_next = ST_CEN;
            ST_CEN:   state_next = ST_PASS;
            ST_PASS:  if (pass_done) state_next = ST_FIN;
            ST_FIN:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control and running state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            limit_reg     <= MASS_LIMIT_RESET;
            count_reg     <= '0;
            reject_reg    <= 1'b0;
            bad_reg       <= 1'b0;
            msum_reg      <= '0;
            mom_x_reg     <= '0;
            mom_y_reg     <= '0;
            mom_z_reg     <= '0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            step_reg      <= '0;
            k_reg         <= '0;
            rv_reg        <= 1'b0;
            sv_reg        <= 1'b0;
            tv_reg        <= 1'b0;
            uv_reg        <= 1'b0;
            vv_reg        <= 1'b0;
            wv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                limit_reg <= cfg_data;

            a_valid_reg <= in_fire && in_ok;
            b_valid_reg <= a_valid_reg;
            if (in_fire && in_ok)
                count_reg <= count_reg + 1'b1;
            if (in_fire && !in_ok)
                reject_reg <= 1'b1;
            if (a_valid_reg)
                msum_reg <= msum_wide[MSUM_W] ? MASS_SUM_MAX : msum_wide[MSUM_W-1:0];
            if (b_valid_reg)
            begin
                mom_x_reg <= sat_add_mom(mom_x_reg, b_mx_reg);
                mom_y_reg <= sat_add_mom(mom_y_reg, b_my_reg);
                mom_z_reg <= sat_add_mom(mom_z_reg, b_mz_reg);
            end

            if (state_reg == ST_DRAIN)
            begin
                bad_reg  <= reject_reg || (msum_reg == '0);
                step_reg <= 6'd63;
            end
            else if (state_reg == ST_DIV)
                step_reg <= step_reg - 1'b1;

            if (state_reg == ST_CEN)
                k_reg <= '0;
            else if (issue)
                k_reg <= k_reg + 1'b1;

            rv_reg <= issue;
            sv_reg <= rv_reg;
            tv_reg <= sv_reg;
            uv_reg <= tv_reg;
            vv_reg <= uv_reg;
            wv_reg <= vv_reg;

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                count_reg     <= '0;
                reject_reg    <= 1'b0;
                msum_reg      <= '0;
                mom_x_reg     <= '0;
                mom_y_reg     <= '0;
                mom_z_reg     <= '0;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // component memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (in_fire && in_ok)
            mem[count_reg[IDX_W-1:0]] <= in_entry;
        if (issue)
            mem_q <= mem[k_reg[IDX_W-1:0]];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        a_mass_reg <= in_mass;
        a_px_reg   <= in_px;
        a_py_reg   <= in_py;
        a_pz_reg   <= in_pz;
        b_mx_reg   <= 56'(a_mass_reg) * 56'(a_px_reg);
        b_my_reg   <= 56'(a_mass_reg) * 56'(a_py_reg);
        b_mz_reg   <= 56'(a_mass_reg) * 56'(a_pz_reg);

        if (state_reg == ST_DRAIN)
        begin
            dvd_x_reg <= mag64(mom_x_reg);
            dvd_y_reg <= mag64(mom_y_reg);
            dvd_z_reg <= mag64(mom_z_reg);
            neg_x_reg <= mom_x_reg[MOM_W-1];
            neg_y_reg <= mom_y_reg[MOM_W-1];
            neg_z_reg <= mom_z_reg[MOM_W-1];
            rem_x_reg <= '0;
            rem_y_reg <= '0;
            rem_z_reg <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            {rem_x_reg, dvd_x_reg} <= div_step(rem_x_reg, dvd_x_reg, msum_reg);
            {rem_y_reg, dvd_y_reg} <= div_step(rem_y_reg, dvd_y_reg, msum_reg);
            {rem_z_reg, dvd_z_reg} <= div_step(rem_z_reg, dvd_z_reg, msum_reg);
        end

        if (state_reg == ST_CEN)
        begin
            cx_reg   <= clamp_c(dvd_x_reg, neg_x_reg);
            cy_reg   <= clamp_c(dvd_y_reg, neg_y_reg);
            cz_reg   <= clamp_c(dvd_z_reg, neg_z_reg);
            accx_reg <= '0;
            accy_reg <= '0;
            accz_reg <= '0;
        end
        else if (wv_reg)
        begin
            accx_reg <= sat_acc(accx_reg, incx_reg);
            accy_reg <= sat_acc(accy_reg, incy_reg);
            accz_reg <= sat_acc(accz_reg, incz_reg);
        end

        // squared offsets from the centre
        sqx_reg    <= sq_dist(mem_q.px, cx_reg);
        sqy_reg    <= sq_dist(mem_q.py, cy_reg);
        sqz_reg    <= sq_dist(mem_q.pz, cz_reg);
        s_mass_reg <= mem_q.mass;
        s_ix_reg   <= mem_q.ix;
        s_iy_reg   <= mem_q.iy;
        s_iz_reg   <= mem_q.iz;

        bx_reg     <= sqy_reg + sqz_reg;
        by_reg     <= sqx_reg + sqz_reg;
        bz_reg     <= sqx_reg + sqy_reg;
        t_mass_reg <= s_mass_reg;
        t_ix_reg   <= s_ix_reg;
        t_iy_reg   <= s_iy_reg;
        t_iz_reg   <= s_iz_reg;

        // mass times squared distance, split at bit 32
        hix_reg  <= 50'(t_mass_reg) * 50'(bx_reg[49:32]);
        hiy_reg  <= 50'(t_mass_reg) * 50'(by_reg[49:32]);
        hiz_reg  <= 50'(t_mass_reg) * 50'(bz_reg[49:32]);
        lox_reg  <= 64'(t_mass_reg) * 64'(bx_reg[31:0]);
        loy_reg  <= 64'(t_mass_reg) * 64'(by_reg[31:0]);
        loz_reg  <= 64'(t_mass_reg) * 64'(bz_reg[31:0]);
        u_ix_reg <= t_ix_reg;
        u_iy_reg <= t_iy_reg;
        u_iz_reg <= t_iz_reg;

        termx_reg <= shr34(hix_reg, lox_reg);
        termy_reg <= shr34(hiy_reg, loy_reg);
        termz_reg <= shr34(hiz_reg, loz_reg);
        v_ix_reg  <= u_ix_reg;
        v_iy_reg  <= u_iy_reg;
        v_iz_reg  <= u_iz_reg;

        incx_reg <= 49'(termx_reg) + 49'(v_ix_reg);
        incy_reg <= 49'(termy_reg) + 49'(v_iy_reg);
        incz_reg <= 49'(termz_reg) + 49'(v_iz_reg);

        if (out_load)
        begin
            out_user_reg <= res_ok;
            out_data_reg <= res_ok
                ? {3'd0, accz_reg, accy_reg, accx_reg, cz_reg, cy_reg, cx_reg, msum_reg}
                : '0;
        end
    end

endmodule

// ===== design/cmp_checker.sv =====
// Port-level checker for the mass properties core, bound to the top level.
module cmp_checker
    import cmp_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  s_tlast,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a failed set carries nothing but zeros
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("invalid result with non-zero payload");

    // a good set has mass and non-zero inertias
    a_good_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[39:0] != '0 && m_tdata[174:112] != '0
            && m_tdata[237:175] != '0 && m_tdata[300:238] != '0)
        else $error("valid result with zero total");

    // input stalls after a closing transaction, for the drain and any compute pass
    a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken straight after a closing transaction");

endmodule

bind composite_mass_properties_core cmp_checker u_cmp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/sv/composite_mass_properties_core_tb.sv =====
// Self-checking testbench for the composite mass properties core.
module composite_mass_properties_core_tb;
    import cmp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 200;

    typedef struct {
        bit                has_id;
        logic [MASS_W-1:0] mass;
        logic [POS_W-1:0]  px, py, pz;
        logic [INER_W-1:0] ix, iy, iz;
        bit                last;
    } component_t;

    typedef struct {
        bit                valid;
        logic [MSUM_W-1:0] tmass;
        logic [POS_W-1:0]  cx, cy, cz;
        logic [TOT_W-1:0]  ix, iy, iz;
    } body_props_t;

    // Tracks the running set and predicts the body properties on each last component
    class mass_props_board;
        logic [LIMIT_W-1:0] mass_limit;
        comp_entry_t        parts[MAX_COMPONENTS];
        int                 count;
        logic [63:0]        mass_sum;
        longint             mom_x, mom_y, mom_z;
        bit                 rejected;
        body_props_t        pending[$];
        string              notes[$];

        function new();
            mass_limit = MASS_LIMIT_RESET;
            clear_set();
        endfunction

        function void clear_set();
            count = 0;
            mass_sum = 0;
            mom_x = 0;
            mom_y = 0;
            mom_z = 0;
            rejected = 0;
        endfunction

        function longint add_moment(longint s, longint m, longint p);
            logic signed [127:0] t;
            t = 128'(s) + 128'(m) * 128'(p);
            if (t > 128'(64'sh7fffffffffffffff)) return 64'sh7fffffffffffffff;
            if (t < -128'sh8000000000000000) return 64'sh8000000000000000;
            return longint'(t);
        endfunction

        function logic [127:0] add_inertia(logic [127:0] s, logic [127:0] p);
            logic [127:0] t;
            t = s + p;
            return (t >= 128'(INERTIA_MAX)) ? 128'(INERTIA_MAX) : t;
        endfunction

        function longint clamp_centre(longint c);
            if (c > 8388607) return 8388607;
            if (c < -8388608) return -8388608;
            return c;
        endfunction

        function void note_component(component_t c);
            longint m, ix, iy, iz, cx, cy, cz, dx, dy, dz;
            logic [127:0] ox, oy, oz, dx2, dy2, dz2, a;
            body_props_t r;
            m  = longint'(signed'(c.mass));
            ix = longint'(signed'(c.ix));
            iy = longint'(signed'(c.iy));
            iz = longint'(signed'(c.iz));
            if (!rejected) begin
                if (!c.has_id || m <= 0 || m > longint'(mass_limit) || ix < 0 || iy < 0
                    || iz < 0 || count >= MAX_COMPONENTS)
                    rejected = 1;
                else begin
                    parts[count] = '{c.mass, c.px, c.py, c.pz, c.ix, c.iy, c.iz};
                    count++;
                    mass_sum += 64'(m);
                    if (mass_sum > 64'(MASS_SUM_MAX)) mass_sum = 64'(MASS_SUM_MAX);
                    mom_x = add_moment(mom_x, m, longint'(signed'(c.px)));
                    mom_y = add_moment(mom_y, m, longint'(signed'(c.py)));
                    mom_z = add_moment(mom_z, m, longint'(signed'(c.pz)));
                end
            end
            if (!c.last) return;
            r = '{default: 0};
            if (!rejected && mass_sum != 0) begin
                cx = clamp_centre(mom_x / longint'(mass_sum));
                cy = clamp_centre(mom_y / longint'(mass_sum));
                cz = clamp_centre(mom_z / longint'(mass_sum));
                ox = 0;
                oy = 0;
                oz = 0;
                for (int k = 0; k < count; k++) begin
                    a  = 128'(parts[k].mass);
                    dx = longint'(parts[k].px) - cx;
                    dy = longint'(parts[k].py) - cy;
                    dz = longint'(parts[k].pz) - cz;
                    dx2 = 128'(dx * dx);
                    dy2 = 128'(dy * dy);
                    dz2 = 128'(dz * dz);
                    ox = add_inertia(ox, 128'(parts[k].ix));
                    ox = add_inertia(ox, (a * (dy2 + dz2)) >> 34);
                    oy = add_inertia(oy, 128'(parts[k].iy));
                    oy = add_inertia(oy, (a * (dx2 + dz2)) >> 34);
                    oz = add_inertia(oz, 128'(parts[k].iz));
                    oz = add_inertia(oz, (a * (dx2 + dy2)) >> 34);
                end
                if (ox != 0 && oy != 0 && oz != 0) begin
                    r.valid = 1;
                    r.tmass = mass_sum[MSUM_W-1:0];
                    r.cx = cx[POS_W-1:0];
                    r.cy = cy[POS_W-1:0];
                    r.cz = cz[POS_W-1:0];
                    r.ix = ox[TOT_W-1:0];
                    r.iy = oy[TOT_W-1:0];
                    r.iz = oz[TOT_W-1:0];
                end
            end
            pending.push_back(r);
            clear_set();
        endfunction

        function void check_result(body_props_t got);
            body_props_t e;
            if (pending.size() == 0) begin
                notes.push_back("result transaction with nothing expected");
                return;
            end
            e = pending.pop_front();
            if (got.valid != e.valid)
                notes.push_back($sformatf("valid_res got %0d exp %0d", got.valid, e.valid));
            if (got.tmass != e.tmass)
                notes.push_back($sformatf("total_mass got %0d exp %0d", got.tmass, e.tmass));
            if (got.cx != e.cx) notes.push_back($sformatf("center_x got %h exp %h", got.cx, e.cx));
            if (got.cy != e.cy) notes.push_back($sformatf("center_y got %h exp %h", got.cy, e.cy));
            if (got.cz != e.cz) notes.push_back($sformatf("center_z got %h exp %h", got.cz, e.cz));
            if (got.ix != e.ix)
                notes.push_back($sformatf("total_inertia_x got %0d exp %0d", got.ix, e.ix));
            if (got.iy != e.iy)
                notes.push_back($sformatf("total_inertia_y got %0d exp %0d", got.iy, e.iy));
            if (got.iz != e.iz)
                notes.push_back($sformatf("total_inertia_z got %0d exp %0d", got.iz, e.iz));
        endfunction
    endclass

    logic                  clk = 0;
    logic                  rst_n = 0;
    logic                  cfg_valid = 0;
    logic                  cfg_ready;
    logic [LIMIT_W-1:0]    cfg_data = '0;
    logic                  s_tvalid = 0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 0;
    logic                  s_tlast = 0;
    logic                  m_tvalid;
    logic                  m_tready = 0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    mass_props_board board = new();
    int  errors = 0;
    int  sets_sent = 0;
    int  comps_sent = 0;
    int  results_seen = 0;
    int  valid_results = 0;
    bit  steady = 0;
    int  hold_requests = 0;
    int  hold_served = 0;
    int  hold_left = 0;

    always #1 clk = ~clk;

    composite_mass_properties_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    task automatic report(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic bit idle_now();
        return !steady && ($urandom_range(99) < 31);
    endfunction

    // Receiver: random back-pressure plus one long hold-off
    always @(negedge clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 0;
        end
        else
            m_tready <= rst_n && !idle_now();
    end

    always @(posedge clk) begin
        body_props_t got;
        if (m_tvalid && m_tready) begin
            got.valid = m_tuser;
            got.tmass = m_tdata[39:0];
            got.cx = m_tdata[63:40];
            got.cy = m_tdata[87:64];
            got.cz = m_tdata[111:88];
            got.ix = m_tdata[174:112];
            got.iy = m_tdata[237:175];
            got.iz = m_tdata[300:238];
            results_seen++;
            if (got.valid) valid_results++;
            board.check_result(got);
            while (board.notes.size() > 0) report(board.notes.pop_front());
        end
    end

    // Watchdog on cycles with no transaction anywhere
    always @(posedge clk) begin
        int quiet;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !rst_n)
            quiet = 0;
        else
            quiet++;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_component(component_t c);
        @(negedge clk);
        while (idle_now()) begin
            s_tvalid <= 0;
            @(negedge clk);
        end
        s_tvalid <= 1;
        s_tuser  <= c.has_id;
        s_tlast  <= c.last;
        s_tdata  <= {c.iz, c.iy, c.ix, c.pz, c.py, c.px, c.mass};
        do @(posedge clk); while (!s_tready);
        board.note_component(c);
        comps_sent++;
        if (c.last) sets_sent++;
    endtask

    task automatic wait_drained();
        while (board.pending.size() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] value);
        @(negedge clk);
        s_tvalid <= 0;
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        board.mass_limit = value;
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    function automatic component_t make_good();
        component_t c;
        logic [31:0] lim;
        lim = (board.mass_limit == 0) ? 32'd1 : 32'(board.mass_limit);
        c.has_id = 1;
        case ($urandom_range(3))
            0: c.mass = $urandom_range(lim < 100 ? lim : 100, 1);
            1: c.mass = lim;
            default: c.mass = $urandom_range(lim, 1);
        endcase
        if ($urandom_range(3) == 0) begin
            c.px = $urandom_range(2000) - 1000;
            c.py = $urandom_range(2000) - 1000;
            c.pz = $urandom_range(2000) - 1000;
        end
        else begin
            c.px = $urandom;
            c.py = $urandom;
            c.pz = $urandom;
        end
        c.ix = ($urandom_range(9) == 0) ? 32'd0 : ($urandom & 32'h7fffffff);
        c.iy = ($urandom_range(9) == 0) ? 32'd0 : ($urandom & 32'h7fffffff);
        c.iz = ($urandom_range(9) == 0) ? 32'd0 : ($urandom & 32'h7fffffff);
        c.last = 0;
        return c;
    endfunction

    function automatic component_t make_bad();
        component_t c;
        c = make_good();
        case ($urandom_range(5))
            0: c.has_id = 0;
            1: c.mass = $urandom | 32'h80000000;
            2: c.mass = 0;
            3: c.mass = (board.mass_limit == {LIMIT_W{1'b1}}) ? $urandom : board.mass_limit + 1;
            4: c.ix = $urandom | 32'h80000000;
            default: begin
                c.iy = $urandom | 32'h80000000;
                c.iz = $urandom;
            end
        endcase
        return c;
    endfunction

    task automatic send_set(int n, int bad_pct);
        component_t c;
        for (int i = 0; i < n; i++) begin
            c = ($urandom_range(99) < bad_pct) ? make_bad() : make_good();
            c.last = (i == n - 1);
            send_component(c);
        end
    endtask

    task automatic random_sets(int items);
        int n, done;
        done = 0;
        while (done < items) begin
            case ($urandom_range(49))
                0: n = 64;
                1: n = 65 + $urandom_range(2);
                default: n = $urandom_range(8, 1);
            endcase
            send_set(n, ($urandom_range(9) < 2) ? 30 : 0);
            done += n;
        end
    endtask

    task automatic directed();
        component_t c;
        // extremes of a single accepted component
        c = '{1, MASS_LIMIT_RESET, 24'h7fffff, 24'h7fffff, 24'h7fffff,
              32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1};
        send_component(c);
        // lone component with zero own inertia on one axis: zero total
        c = '{1, 32'd1, 24'h800000, 24'h800000, 24'h800000, 32'd0, 32'd5, 32'd5, 1};
        send_component(c);
        // two components at opposite corners
        c = '{1, 32'd1, 24'h800000, 24'h800000, 24'h800000, 32'd0, 32'd0, 32'd0, 0};
        send_component(c);
        c = '{1, MASS_LIMIT_RESET, 24'h7fffff, 24'h7fffff, 24'h7fffff, 32'd0, 32'd0, 32'd0, 1};
        send_component(c);
        // each field rejection reason; the first and last are followed by a good last component
        c = '{0, 32'd100, 24'd5, 24'd5, 24'd5, 32'd1, 32'd1, 32'd1, 0};
        send_component(c);
        c = make_good(); c.last = 1; send_component(c);
        c = '{1, 32'd0, 24'd5, 24'd5, 24'd5, 32'd1, 32'd1, 32'd1, 1};
        send_component(c);
        c = '{1, 32'h80000000, 24'd5, 24'd5, 24'd5, 32'd1, 32'd1, 32'd1, 1};
        send_component(c);
        c = '{1, 32'hffffffff, 24'd5, 24'd5, 24'd5, 32'd1, 32'd1, 32'd1, 1};
        send_component(c);
        c = '{1, MASS_LIMIT_RESET + 1, 24'd5, 24'd5, 24'd5, 32'd1, 32'd1, 32'd1, 1};
        send_component(c);
        c = '{1, 32'd7, 24'd5, 24'd5, 24'd5, 32'h80000000, 32'd1, 32'd1, 1};
        send_component(c);
        c = '{1, 32'd7, 24'd5, 24'd5, 24'd5, 32'd1, 32'hffffffff, 32'd1, 1};
        send_component(c);
        c = '{1, 32'd7, 24'd5, 24'd5, 24'd5, 32'd1, 32'd1, 32'h80000000, 0};
        send_component(c);
        c = make_good(); c.last = 1; send_component(c);
        // rounding of the centre toward zero with negative moments
        c = '{1, 32'd2, 24'hfffffd, 24'd3, 24'd0, 32'd1, 32'd1, 32'd1, 0};
        send_component(c);
        c = '{1, 32'd1, 24'd0, 24'd0, 24'hffffff, 32'd1, 32'd1, 32'd1, 1};
        send_component(c);
    endtask

    initial begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        directed();
        // the receiver sits out a long stretch while sets keep coming
        hold_requests++;
        random_sets(300);
        write_limit(31'd1);
        random_sets(120);
        write_limit({LIMIT_W{1'b1}});
        steady = 1;
        random_sets(200);
        steady = 0;
        random_sets(200);
        write_limit(31'd0);
        random_sets(40);
        write_limit(31'($urandom_range(100000, 1)));
        random_sets(300);
        write_limit(MASS_LIMIT_RESET);
        random_sets(370);
        @(negedge clk);
        s_tvalid <= 0;
        while (board.pending.size() > 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d components in %0d sets, %0d results (%0d valid)",
                 comps_sent, sets_sent, results_seen, valid_results);
        $display("mass limits: default, 1, full scale, zero and a random value");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
design/cmp_pkg.sv
design/composite_mass_properties_core.sv
design/cmp_checker.sv
tb/sv/composite_mass_properties_core_tb.sv
